/* rtl/rtu_pkg.sv */
package rtu_pkg;

  // Field widths fixed by the interface
  localparam int unsigned TimeW     = 32;
  localparam int unsigned OrderW    = 32;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned PortW     = 16;
  localparam int unsigned HandleW   = 16;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned LimitW    = 9;
  localparam int unsigned PeerW     = 33;
  localparam int unsigned CountW    = 8;
  localparam int unsigned SocketW   = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 1;

  // At most this many resends are reported per tick
  localparam int unsigned MaxResults = 16;
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);

  localparam logic signed [LimitW-1:0] LimitForever = -9'sd1;
  localparam logic [CountW-1:0]        CountMax     = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE = 1'b0,
    CFG_SOCKET = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_TICK = 2'd1,
    ACT_ACK  = 2'd2,
    ACT_DROP = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_SEND      = 2'd0,
    KIND_RESEND    = 2'd1,
    KIND_UNTRACKED = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_PRIME,
    ST_EVAL,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [OrderW-1:0]           order;
    logic [PeerW-1:0]            peer;
    logic [AddrW-1:0]            addr;
    logic [PortW-1:0]            port;
    logic [HandleW-1:0]          handle;
    logic [IntervalW-1:0]        interval;
    logic signed [LimitW-1:0]    limit;
    logic [CountW-1:0]           count;
    logic [TimeW-1:0]            last_time;
  } entry_t;

  typedef struct packed {
    kind_e               kind;
    logic [AddrW-1:0]    addr;
    logic [PortW-1:0]    port;
    logic [HandleW-1:0]  handle;
    logic [OrderW-1:0]   order;
  } result_t;

  // Verdict of the evaluation unit on one table entry
  typedef struct packed {
    logic   resend;
    logic   keep;
    entry_t entry;
  } verdict_t;

endpackage

/* rtl/rtu_entry_mem.sv */
module rtu_entry_mem import rtu_pkg::*; #(
  parameter int unsigned Depth = 16,
  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  entry_t          wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rtu_entry_eval.sv */
module rtu_entry_eval import rtu_pkg::*; (
  input  action_e            action_i,
  input  logic [TimeW-1:0]   now_i,
  input  logic [OrderW-1:0]  order_i,
  input  logic [PeerW-1:0]   peer_i,
  input  entry_t             entry_i,
  output verdict_t           verdict_o
);

  logic [TimeW-1:0]   elapsed;
  logic               due;
  logic [CountW-1:0]  count_upd;
  logic               expired;
  entry_t             entry_upd;

  // Elapsed time wraps at 32 bits; resend only when strictly past the interval
  assign elapsed = now_i - entry_i.last_time;
  assign due     = elapsed > {{(TimeW - IntervalW){1'b0}}, entry_i.interval};

  assign count_upd = (due && (entry_i.count != CountMax)) ? entry_i.count + 1'b1
                                                         : entry_i.count;

  // Signed compare of the updated count against the limit
  assign expired = (entry_i.limit != LimitForever) &&
                   ($signed({1'b0, count_upd}) >= entry_i.limit);

  always_comb begin
    entry_upd = entry_i;
    if (action_i == ACT_TICK) begin
      entry_upd.count = count_upd;
      if (due) begin
        entry_upd.last_time = now_i;
      end
    end
  end

  always_comb begin
    verdict_o.entry  = entry_upd;
    verdict_o.resend = 1'b0;
    verdict_o.keep   = 1'b1;
    unique case (action_i)
      ACT_TICK: begin
        verdict_o.resend = due;
        verdict_o.keep   = !expired;
      end
      ACT_ACK:  verdict_o.keep = entry_i.order != order_i;
      ACT_DROP: verdict_o.keep = entry_i.peer != peer_i;
      default:  verdict_o.keep = 1'b1;
    endcase
  end

endmodule

/* rtl/retransmit_table_unit.sv */
// Retransmit table: holds up to TableDepth packets awaiting acknowledgement.
// A send transaction transmits the packet once (kind 0) and records it, or
// transmits it untracked (kind 2) when the table is full. A tick resends every
// entry whose wrapped elapsed time exceeds its interval (kind 1), bumps its
// saturating retry count, then drops entries whose count reached a limit other
// than -1; at most 16 resends are reported per tick, later ones still update
// their entries. An ack removes all entries with the given order, a drop all
// entries of a peer; neither yields a result. Every transaction is ignored
// while enable is clear. The last result of a transaction carries last_o.
// Timing: one transaction at a time. A send passes through the SEND and FLUSH
// states before the next acceptance; a tick, ack or drop on n > 0 occupied
// entries streams them one per cycle, unless a resend stalls on a full result
// path, through the single memory read port and the one evaluation unit, while
// survivors are written back compacted in insertion order. A tick, ack or drop
// on an empty table, and any transaction while disabled, leaves the block idle.
// Backpressure on the result channel adds stall cycles. The table memory needs
// no clearing pass: an occupancy count marks the live entries.
module retransmit_table_unit import rtu_pkg::*; #(
  parameter int unsigned TableDepth = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,

  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               action_i,
  input  logic [TimeW-1:0]         current_time_i,
  input  logic [OrderW-1:0]        order_i,
  input  logic [AddrW-1:0]         dest_addr_i,
  input  logic [PortW-1:0]         dest_port_i,
  input  logic [HandleW-1:0]       packet_handle_i,
  input  logic [IntervalW-1:0]     retry_interval_i,
  input  logic signed [LimitW-1:0] retry_limit_i,
  input  logic [PeerW-1:0]         peer_id_i,

  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [1:0]               kind_o,
  output logic [AddrW-1:0]         out_addr_o,
  output logic [PortW-1:0]         out_port_o,
  output logic [HandleW-1:0]       out_handle_o,
  output logic [OrderW-1:0]        out_order_o,
  output logic                     last_o
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  // Configuration registers
  logic               enable_q;
  logic [SocketW-1:0] socket_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      socket_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ENABLE: enable_q <= cfg_data_i[0];
        CFG_SOCKET: socket_q <= cfg_data_i[SocketW-1:0];
        default: ;
      endcase
    end
  end

  // Captured transaction
  action_e                  act_q;
  logic [TimeW-1:0]         time_q;
  logic [OrderW-1:0]        order_q;
  logic [AddrW-1:0]         addr_q;
  logic [PortW-1:0]         port_q;
  logic [HandleW-1:0]       handle_q;
  logic [IntervalW-1:0]     interval_q;
  logic signed [LimitW-1:0] limit_q;
  logic [PeerW-1:0]         peer_q;

  // Sequencer state
  state_e             state_q, state_d;
  logic [CntW-1:0]    n_q, n_d;
  logic [CntW-1:0]    r_q, r_d;
  logic [CntW-1:0]    w_q, w_d;
  logic [ResCntW-1:0] cnt_q, cnt_d;

  // Held result and output register
  logic    pend_valid_q, pend_valid_d;
  result_t pend_q, pend_d;
  logic    out_valid_q, out_valid_d;
  logic    out_last_q, out_last_d;
  result_t out_q, out_d;

  // Memory and evaluation unit
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  entry_t          mem_wdata, mem_rdata;
  verdict_t        verdict;

  logic            in_fire;
  logic            out_free;
  logic            need_emit;
  logic            advance;
  logic            out_load;
  logic [CntW-1:0] r_next;
  logic            table_full;
  logic            scan_end;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign r_next     = r_q + 1'b1;
  assign scan_end   = (r_next == n_q);
  assign table_full = (n_q == CntW'(TableDepth));

  // A resend is reported while below the cap; stall only when both the held
  // result and the output register are occupied
  assign need_emit = (act_q == ACT_TICK) && verdict.resend &&
                     (cnt_q < ResCntW'(MaxResults));
  assign advance   = !(need_emit && pend_valid_q && !out_free);

  rtu_entry_mem #(
    .Depth (TableDepth)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rtu_entry_eval u_eval (
    .action_i  (act_q),
    .now_i     (time_q),
    .order_i   (order_q),
    .peer_i    (peer_q),
    .entry_i   (mem_rdata),
    .verdict_o (verdict)
  );

  // Capture the transaction on acceptance
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q      <= action_e'(action_i);
      time_q     <= current_time_i;
      order_q    <= order_i;
      addr_q     <= dest_addr_i;
      port_q     <= dest_port_i;
      handle_q   <= packet_handle_i;
      interval_q <= retry_interval_i;
      limit_q    <= retry_limit_i;
      peer_q     <= peer_id_i;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && enable_q) begin
          if (action_e'(action_i) == ACT_SEND) begin
            state_d = ST_SEND;
          end else if (n_q != '0) begin
            state_d = ST_PRIME;
          end
        end
      end
      ST_SEND:  state_d = ST_FLUSH;
      ST_PRIME: state_d = ST_EVAL;
      ST_EVAL: begin
        if (advance && scan_end) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = w_q[IdxW-1:0];
    mem_raddr    = r_next[IdxW-1:0];
    mem_wdata    = verdict.entry;
    n_d          = n_q;
    r_d          = r_q;
    w_d          = w_q;
    cnt_d        = cnt_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_load     = 1'b0;
    out_last_d   = out_last_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: ;
      ST_SEND: begin
        // Record the packet at the tail when there is room
        mem_waddr           = n_q[IdxW-1:0];
        mem_wdata.order     = order_q;
        mem_wdata.peer      = {1'b0, addr_q} + {{(PeerW - PortW){1'b0}}, port_q}
                              + {{(PeerW - SocketW){1'b0}}, socket_q};
        mem_wdata.addr      = addr_q;
        mem_wdata.port      = port_q;
        mem_wdata.handle    = handle_q;
        mem_wdata.interval  = interval_q;
        mem_wdata.limit     = limit_q;
        mem_wdata.count     = '0;
        mem_wdata.last_time = time_q;
        mem_we              = !table_full;
        if (!table_full) begin
          n_d = n_q + 1'b1;
        end
        pend_valid_d = 1'b1;
        pend_d.kind   = table_full ? KIND_UNTRACKED : KIND_SEND;
        pend_d.addr   = addr_q;
        pend_d.port   = port_q;
        pend_d.handle = handle_q;
        pend_d.order  = order_q;
      end
      ST_PRIME: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
        r_d       = '0;
        w_d       = '0;
        cnt_d     = '0;
      end
      ST_EVAL: begin
        if (advance) begin
          // Write back survivors, closing gaps
          if (verdict.keep) begin
            mem_we = 1'b1;
            w_d    = w_q + 1'b1;
          end
          if (scan_end) begin
            n_d = verdict.keep ? w_q + 1'b1 : w_q;
          end else begin
            mem_re = 1'b1;
            r_d    = r_next;
          end
          if (need_emit) begin
            cnt_d = cnt_q + 1'b1;
            if (pend_valid_q) begin
              out_load   = 1'b1;
              out_d      = pend_q;
              out_last_d = 1'b0;
            end
            pend_valid_d  = 1'b1;
            pend_d.kind   = KIND_RESEND;
            pend_d.addr   = verdict.entry.addr;
            pend_d.port   = verdict.entry.port;
            pend_d.handle = verdict.entry.handle;
            pend_d.order  = verdict.entry.order;
          end
        end
      end
      ST_FLUSH: begin
        // Release the held result as the last one of the transaction
        if (pend_valid_q && out_free) begin
          out_load     = 1'b1;
          out_d        = pend_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      n_q          <= '0;
      r_q          <= '0;
      w_q          <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      n_q          <= n_d;
      r_q          <= r_d;
      w_q          <= w_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_q.kind;
  assign out_addr_o   = out_q.addr;
  assign out_port_o   = out_q.port;
  assign out_handle_o = out_q.handle;
  assign out_order_o  = out_q.order;
  assign last_o       = out_last_q;

  // Occupancy never exceeds the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(TableDepth))
    else $error("occupancy count beyond table depth");

  // Compaction writes never overtake the read pointer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> (w_q <= r_q) && (r_q < n_q))
    else $error("scan pointers out of order");

  // Never overwrite a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten");

  // Nothing is left held when the block goes idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("held result left behind");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rtu_pkg::*;

  localparam int unsigned TableDepth    = 16;
  localparam int unsigned HalfPeriod    = 5;
  localparam int unsigned ResetCycles   = 7;
  // Covers the longest scan with margin
  localparam int unsigned TailCycles    = 40;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SoakTicks     = 48;
  localparam int unsigned PhaseItems    = 30;
  localparam int unsigned OffItems      = 15;

  // Expected-result codes of a directed row
  localparam int Predicted = -1;
  localparam int NoResult  = 0;
  localparam int OneResult = 1;

  typedef struct packed {
    action_e                  action;
    logic [TimeW-1:0]         now;
    logic [OrderW-1:0]        order;
    logic [AddrW-1:0]         addr;
    logic [PortW-1:0]         port;
    logic [HandleW-1:0]       handle;
    logic [IntervalW-1:0]     interval;
    logic signed [LimitW-1:0] limit;
    logic [PeerW-1:0]         peer;
  } in_t;

  typedef struct packed {
    kind_e               kind;
    logic [AddrW-1:0]    addr;
    logic [PortW-1:0]    port;
    logic [HandleW-1:0]  handle;
    logic [OrderW-1:0]   order;
    logic                last;
  } tx_t;

  typedef struct {
    in_t   item;
    int    reps;
    int    nres;
    kind_e kind;
  } row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_index_i;
  logic [CfgDataW-1:0]      cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [1:0]               action_i;
  logic [TimeW-1:0]         current_time_i;
  logic [OrderW-1:0]        order_i;
  logic [AddrW-1:0]         dest_addr_i;
  logic [PortW-1:0]         dest_port_i;
  logic [HandleW-1:0]       packet_handle_i;
  logic [IntervalW-1:0]     retry_interval_i;
  logic signed [LimitW-1:0] retry_limit_i;
  logic [PeerW-1:0]         peer_id_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [1:0]               kind_o;
  logic [AddrW-1:0]         out_addr_o;
  logic [PortW-1:0]         out_port_o;
  logic [HandleW-1:0]       out_handle_o;
  logic [OrderW-1:0]        out_order_o;
  logic                     last_o;

  retransmit_table_unit #(.TableDepth(TableDepth)) DUT (.*);

  always #HalfPeriod clk_i = ~clk_i;

  // Shadow copy of the block: configuration and occupied slots in insertion order
  logic        net_enable   = 1'b0;
  logic [15:0] local_socket = '0;
  entry_t      shadow_slots [$];

  tx_t  caused_tx [$];   // transmissions caused by the transaction just accepted
  tx_t  pending_tx [$];  // transmissions still to appear on the result channel
  row_t plan [$];

  logic [TimeW-1:0]  now_ms;
  logic [AddrW-1:0]  pool_addr [4];
  logic [PortW-1:0]  pool_port [4];

  int unsigned send_calm, sink_calm;
  logic        hold_armed = 1'b0;
  logic        hold_done  = 1'b0;

  int unsigned fail_count, results_checked, untracked_sends, peak_slots;
  int unsigned settings_applied, quiet_cycles;
  int unsigned action_seen [4];

  // Draw an idle count; now and then start a stretch with no idling at all
  function automatic int unsigned draw_idle(ref int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic void note_tx(input kind_e k, input logic [AddrW-1:0] a,
                                  input logic [PortW-1:0] p, input logic [HandleW-1:0] h,
                                  input logic [OrderW-1:0] o);
    tx_t t;
    t.kind   = k;
    t.addr   = a;
    t.port   = p;
    t.handle = h;
    t.order  = o;
    t.last   = 1'b0;
    caused_tx = {caused_tx, t};
  endfunction

  // Advance the shadow table by one transaction and collect what it transmits
  function automatic void step_table(input in_t it);
    entry_t           e;
    entry_t           kept [$];
    logic [TimeW-1:0] elapsed;
    caused_tx.delete();
    if (!net_enable) return;
    case (it.action)
      ACT_SEND: begin
        if (shadow_slots.size() < TableDepth) begin
          e.order     = it.order;
          e.peer      = PeerW'(it.addr) + PeerW'(it.port) + PeerW'(local_socket);
          e.addr      = it.addr;
          e.port      = it.port;
          e.handle    = it.handle;
          e.interval  = it.interval;
          e.limit     = it.limit;
          e.count     = '0;
          e.last_time = it.now;
          shadow_slots = {shadow_slots, e};
          if (shadow_slots.size() > peak_slots) peak_slots = shadow_slots.size();
          note_tx(KIND_SEND, it.addr, it.port, it.handle, it.order);
        end else begin
          // Full table: transmit anyway, record nothing
          untracked_sends++;
          note_tx(KIND_UNTRACKED, it.addr, it.port, it.handle, it.order);
        end
      end
      ACT_TICK: begin
        foreach (shadow_slots[i]) begin
          e = shadow_slots[i];
          // Elapsed time wraps at 32 bits; resend only when strictly past the interval
          elapsed = it.now - e.last_time;
          if (elapsed > TimeW'(e.interval)) begin
            if (e.count != CountMax) e.count = e.count + 1'b1;
            e.last_time = it.now;
            if (caused_tx.size() < MaxResults) begin
              note_tx(KIND_RESEND, e.addr, e.port, e.handle, e.order);
            end
          end
          // Keep forever at limit -1; otherwise drop once count reaches the signed limit
          if (e.limit == LimitForever || $signed({1'b0, e.count}) < e.limit) begin
            kept = {kept, e};
          end
        end
        shadow_slots = kept;
      end
      ACT_ACK: begin
        foreach (shadow_slots[i]) begin
          if (shadow_slots[i].order != it.order) kept = {kept, shadow_slots[i]};
        end
        shadow_slots = kept;
      end
      default: begin
        foreach (shadow_slots[i]) begin
          if (shadow_slots[i].peer != it.peer) kept = {kept, shadow_slots[i]};
        end
        shadow_slots = kept;
      end
    endcase
  endfunction

  function automatic void row(input action_e a, input logic [TimeW-1:0] now,
                              input logic [OrderW-1:0] ord, input logic [AddrW-1:0] addr,
                              input logic [PortW-1:0] port, input logic [HandleW-1:0] hdl,
                              input logic [IntervalW-1:0] ivl,
                              input logic signed [LimitW-1:0] lim,
                              input logic [PeerW-1:0] peer, input int reps,
                              input int nres, input kind_e kind);
    row_t r;
    r.item.action   = a;
    r.item.now      = now;
    r.item.order    = ord;
    r.item.addr     = addr;
    r.item.port     = port;
    r.item.handle   = hdl;
    r.item.interval = ivl;
    r.item.limit    = lim;
    r.item.peer     = peer;
    r.reps          = reps;
    r.nres          = nres;
    r.kind          = kind;
    plan = {plan, r};
  endfunction

  // Build one random transaction: mostly well-formed traffic against live entries
  function automatic in_t make_item();
    in_t         it;
    int unsigned pick;
    it.action   = action_e'($urandom_range(0, 3));
    it.now      = $urandom();
    it.order    = $urandom();
    it.addr     = $urandom();
    it.port     = PortW'($urandom());
    it.handle   = HandleW'($urandom());
    it.interval = IntervalW'($urandom());
    it.limit    = LimitW'($urandom());
    it.peer     = {1'($urandom_range(0, 1)), $urandom()};
    if ($urandom_range(0, 19) == 0) now_ms = $urandom();
    else now_ms = now_ms + $urandom_range(0, 300);
    // Noise: fully random fields and action
    if ($urandom_range(0, 99) < 15) return it;
    it.now = now_ms;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.action = ACT_SEND;
      if ($urandom_range(0, 1) == 1) begin
        pick    = $urandom_range(0, 3);
        it.addr = pool_addr[pick];
        it.port = pool_port[pick];
      end
      if (shadow_slots.size() != 0 && $urandom_range(0, 7) == 0) begin
        it.order = shadow_slots[$urandom_range(0, shadow_slots.size() - 1)].order;
      end
      it.interval = ($urandom_range(0, 9) == 0) ? IntervalW'($urandom())
                                               : IntervalW'($urandom_range(0, 600));
      it.limit = ($urandom_range(0, 9) == 0) ? LimitW'($urandom())
                                            : LimitW'($urandom_range(0, 6) - 1);
    end else if (pick < 75) begin
      it.action = ACT_TICK;
    end else if (pick < 87) begin
      it.action = ACT_ACK;
      if (shadow_slots.size() != 0) begin
        it.order = shadow_slots[$urandom_range(0, shadow_slots.size() - 1)].order;
      end
    end else begin
      it.action = ACT_DROP;
      if (shadow_slots.size() != 0) begin
        it.peer = shadow_slots[$urandom_range(0, shadow_slots.size() - 1)].peer;
      end
    end
    return it;
  endfunction

  // Offer one transaction after an idle gap, hold it until accepted, then predict.
  // Entered and left at a rising edge; valid stays high when the next gap is zero.
  task automatic drive_item(input in_t it, input int unsigned gap, input int typed_n,
                            input kind_e typed_kind);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= it.action;
    current_time_i   <= it.now;
    order_i          <= it.order;
    dest_addr_i      <= it.addr;
    dest_port_i      <= it.port;
    packet_handle_i  <= it.handle;
    retry_interval_i <= it.interval;
    retry_limit_i    <= it.limit;
    peer_id_i        <= it.peer;
    do @(posedge clk_i); while (!in_ready_o);
    action_seen[it.action]++;
    step_table(it);
    // Rows with a hand-written expectation replace the predicted transmissions
    if (typed_n != Predicted) begin
      caused_tx.delete();
      if (typed_n == OneResult) note_tx(typed_kind, it.addr, it.port, it.handle, it.order);
    end
    if (caused_tx.size() != 0) caused_tx[caused_tx.size() - 1].last = 1'b1;
    foreach (caused_tx[i]) pending_tx = {pending_tx, caused_tx[i]};
  endtask

  task automatic walk_plan();
    in_t it;
    foreach (plan[r]) begin
      it = plan[r].item;
      repeat (plan[r].reps) begin
        drive_item(it, draw_idle(send_calm), plan[r].nres, plan[r].kind);
        it.order = it.order + 1'b1;
      end
    end
    plan.delete();
  endtask

  // Drop valid, wait for every expected transmission, then let a scan with no
  // result run out before touching the registers
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_tx.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // Write both registers on back-to-back edges, keeping the write enable high
  task automatic apply_settings(input logic en, input logic [15:0] sock);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ENABLE;
    cfg_data_i  <= CfgDataW'(en);
    @(posedge clk_i);
    net_enable  = en;
    cfg_index_i <= CFG_SOCKET;
    cfg_data_i  <= sock;
    @(posedge clk_i);
    local_socket = sock;
    cfg_we_i    <= 1'b0;
    settings_applied++;
  endtask

  // Result side: random stalls per result, one long hold-off once armed
  initial begin : sink
    int unsigned stall;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_armed && !hold_done) begin
        stall     = LongHold;
        hold_done = 1'b1;
      end else begin
        stall = draw_idle(sink_calm);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Compare each accepted transmission with the oldest expectation
  always @(posedge clk_i) begin : tx_check
    tx_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_tx.size() == 0) begin
        $error("unexpected transmission: kind %0d order %h", kind_o, out_order_o);
        fail_count++;
      end else begin
        want = pending_tx.pop_front();
        results_checked++;
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, kind_o);
          fail_count++;
        end
        if (out_addr_o !== want.addr) begin
          $error("out_addr: expected %h, actual %h", want.addr, out_addr_o);
          fail_count++;
        end
        if (out_port_o !== want.port) begin
          $error("out_port: expected %h, actual %h", want.port, out_port_o);
          fail_count++;
        end
        if (out_handle_o !== want.handle) begin
          $error("out_handle: expected %h, actual %h", want.handle, out_handle_o);
          fail_count++;
        end
        if (out_order_o !== want.order) begin
          $error("out_order: expected %h, actual %h", want.order, out_order_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // Abort when nothing moves on any port for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    in_t         it;
    int unsigned k, p, n_items;
    logic        en;
    logic [15:0] sock;

    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_index_i      <= CFG_ENABLE;
    cfg_data_i       <= '0;
    in_valid_i       <= 1'b0;
    action_i         <= ACT_SEND;
    current_time_i   <= '0;
    order_i          <= '0;
    dest_addr_i      <= '0;
    dest_port_i      <= '0;
    packet_handle_i  <= '0;
    retry_interval_i <= '0;
    retry_limit_i    <= '0;
    peer_id_i        <= '0;
    now_ms = '0;
    foreach (pool_addr[i]) begin
      pool_addr[i] = $urandom();
      pool_port[i] = PortW'($urandom());
    end
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset the block is disabled: every transaction is swallowed
    row(ACT_SEND, 32'h0, 32'd7, 32'h0A00_0001, 16'd80, 16'd1, 16'd250, 9'sd3, '0,
        1, NoResult, KIND_SEND);
    row(ACT_TICK, 32'hFFFF_FFFF, 32'd7, 32'h0A00_0001, 16'd80, 16'd1, 16'd0, 9'sd3, '0,
        1, NoResult, KIND_SEND);
    walk_plan();
    settle();
    apply_settings(1'b1, 16'hFFFF);

    // All-ones destination with the top socket pushes the peer id into bit 32
    row(ACT_SEND, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        9'sd255, '0, 1, OneResult, KIND_SEND);
    row(ACT_SEND, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, LimitForever, '0,
        1, OneResult, KIND_SEND);
    row(ACT_SEND, 32'd100, 32'd1, 32'h0A00_0001, 16'd5000, 16'd1, 16'd250, 9'sd3, '0,
        1, OneResult, KIND_SEND);
    // Limit below -1 and limit 0 both leave at the first tick
    row(ACT_SEND, 32'd100, 32'd2, 32'h0A00_0002, 16'd5001, 16'd2, 16'd250, -9'sd2, '0,
        1, OneResult, KIND_SEND);
    row(ACT_SEND, 32'd100, 32'd3, 32'h0A00_0003, 16'd5002, 16'd3, 16'hFFFF, 9'sd0, '0,
        1, OneResult, KIND_SEND);
    // Stamped just before the time wraps
    row(ACT_SEND, 32'hFFFF_FF00, 32'd4, 32'h0A00_0004, 16'd5003, 16'd4, 16'd250, 9'sd2,
        '0, 1, OneResult, KIND_SEND);
    row(ACT_TICK, 32'd1, '0, '0, '0, '0, '0, '0, '0, 1, Predicted, KIND_RESEND);
    row(ACT_TICK, 32'd1, '0, '0, '0, '0, '0, '0, '0, 1, Predicted, KIND_RESEND);
    row(ACT_TICK, 32'd352, '0, '0, '0, '0, '0, '0, '0, 1, Predicted, KIND_RESEND);
    row(ACT_ACK, 32'd352, 32'd1, '0, '0, '0, '0, '0, '0, 1, NoResult, KIND_SEND);
    // Second entry with order 0, so the ack below removes two
    row(ACT_SEND, 32'd352, 32'd0, 32'h0A00_0005, 16'd5004, 16'd5, 16'd250, 9'sd3, '0,
        1, OneResult, KIND_SEND);
    row(ACT_ACK, 32'd352, 32'd0, '0, '0, '0, '0, '0, '0, 1, NoResult, KIND_SEND);
    row(ACT_DROP, 32'd352, '0, '0, '0, '0, '0, '0, 33'hFFFF_FFFF + 33'hFFFF + 33'hFFFF,
        1, NoResult, KIND_SEND);
    row(ACT_TICK, 32'h7FFF_FFFF, '0, '0, '0, '0, '0, '0, '0, 1, Predicted, KIND_RESEND);
    // Fill the table, then overflow it once
    row(ACT_SEND, 32'h8000_0000, 32'd100, 32'hC0A8_0001, 16'd8080, 16'h55AA, 16'd1000,
        LimitForever, '0, TableDepth, OneResult, KIND_SEND);
    row(ACT_SEND, 32'h8000_0000, 32'd200, 32'hC0A8_0002, 16'd8081, 16'hAA55, 16'd1000,
        LimitForever, '0, 1, OneResult, KIND_UNTRACKED);
    // Every slot resends: the result cap is reached exactly
    row(ACT_TICK, 32'h8000_0000 + 32'd1001, '0, '0, '0, '0, '0, '0, '0,
        1, Predicted, KIND_RESEND);
    row(ACT_DROP, 32'h8000_0400, '0, '0, '0, '0, '0, '0,
        33'hC0A8_0001 + 33'd8080 + 33'hFFFF, 1, NoResult, KIND_SEND);
    walk_plan();
    settle();
    apply_settings(1'b1, 16'h0000);

    // Soak: resend on every tick; the limit-40 entry leaves at its fortieth
    // resend while the keep-forever entry stays
    it          = '0;
    it.action   = ACT_SEND;
    it.order    = 32'hA5;
    it.addr     = 32'h0A0A_0A0A;
    it.port     = 16'd9000;
    it.limit    = 9'sd40;
    drive_item(it, draw_idle(send_calm), Predicted, KIND_SEND);
    it.order    = 32'hA6;
    it.limit    = LimitForever;
    drive_item(it, draw_idle(send_calm), Predicted, KIND_SEND);
    it.action   = ACT_TICK;
    for (k = 1; k <= SoakTicks; k++) begin
      it.now = k;
      drive_item(it, draw_idle(send_calm), Predicted, KIND_SEND);
    end

    // Random phases, each under its own register setting; arm the long hold-off
    for (p = 0; p < 5; p++) begin
      settle();
      en      = (p != 2);
      n_items = (p == 2) ? OffItems : PhaseItems;
      case (p)
        1:       sock = 16'h0000;
        3:       sock = 16'hFFFF;
        default: sock = 16'($urandom());
      endcase
      apply_settings(en, sock);
      if (p == 0) hold_armed = 1'b1;
      for (k = 0; k < n_items; k++) begin
        drive_item(make_item(), draw_idle(send_calm), Predicted, KIND_SEND);
      end
    end
    settle();

    $display("covered %0d transactions: %0d send, %0d tick, %0d ack, %0d drop",
             action_seen[0] + action_seen[1] + action_seen[2] + action_seen[3],
             action_seen[ACT_SEND], action_seen[ACT_TICK], action_seen[ACT_ACK],
             action_seen[ACT_DROP]);
    $display("%0d transmissions checked, %0d untracked, peak %0d of %0d slots, %0d settings",
             results_checked, untracked_sends, peak_slots, TableDepth, settings_applied);
    if (fail_count == 0 && pending_tx.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
